// ----- rtl/gdd_pkg.sv -----
package gdd_pkg;

    typedef enum logic [2:0] {
        MOTION_NONE  = 3'd0,
        MOTION_LEFT  = 3'd1,
        MOTION_RIGHT = 3'd2,
        MOTION_UP    = 3'd3,
        MOTION_DOWN  = 3'd4,
        MOTION_NEAR  = 3'd5,
        MOTION_FAR   = 3'd6
    } motion_t;

    typedef enum logic [1:0] {
        PROX_NONE = 2'd0,
        PROX_NEAR = 2'd1,
        PROX_FAR  = 2'd2
    } prox_t;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_SWIPE     = 2'd1;
    localparam logic [1:0] REG_NEAR_FAR  = 2'd2;

    // command passed from front to back
    typedef enum logic [1:0] {
        CMD_BATCH = 2'd0,
        CMD_END   = 2'd1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] first;
        logic [31:0] last;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ACC,
        ST_DIR,
        ST_TALLY,
        ST_DONE
    } back_state_t;

    typedef enum logic [1:0] {
        FS_COLLECT,
        FS_SCAN_FWD,
        FS_SCAN_BWD,
        FS_ISSUE
    } front_state_t;

endpackage

// ----- rtl/gesture_direction_decoder.sv -----
// channel   handshake      payload
// input     push / full    kind, up/down/left/right_level, batch_last
// result    pop / empty    gesture
// config    cfg_we         cfg_index, cfg_data
// A batch end with over four stored samples scans the store, one read per
// cycle; if a sample passes the threshold, the back end then runs four
// divisions and the ACC, DIR, TALLY and, if needed, DONE steps. full is high
// while the front scans or waits on the back end, or while a gesture end waits
// on an unread result. Reset is asynchronous; the sample store is not cleared.
module gesture_direction_decoder
    import gdd_pkg::*;
#(
    parameter int BATCH_DEPTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       kind,
    input  logic [7:0] up_level,
    input  logic [7:0] down_level,
    input  logic [7:0] left_level,
    input  logic [7:0] right_level,
    input  logic       batch_last,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] gesture,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    logic [7:0] thr_reg, sw_reg, nf_reg;
    logic       cmd_valid, cmd_ready, res_valid;
    cmd_t       cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 8'd10;
            sw_reg  <= 8'd50;
            nf_reg  <= 8'd20;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD: thr_reg <= cfg_data;
                REG_SWIPE:     sw_reg  <= cfg_data;
                REG_NEAR_FAR:  nf_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    gdd_front #(.BATCH_DEPTH(BATCH_DEPTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .up_level    (up_level),
        .down_level  (down_level),
        .left_level  (left_level),
        .right_level (right_level),
        .batch_last  (batch_last),
        .threshold   (thr_reg),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_ready   (cmd_ready)
    );

    gdd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_ready   (cmd_ready),
        .swipe_sens  (sw_reg),
        .nf_sens     (nf_reg),
        .res_valid   (res_valid),
        .res_gesture (gesture),
        .res_ready   (pop)
    );

    assign empty = !res_valid;
endmodule

// ----- rtl/gdd_div.sv -----
// Signed ratio (a-b)*100/(a+b), restoring divider, one quotient bit per cycle.
module gdd_div
    import gdd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [7:0]        a,
    input  logic [7:0]        b,
    output logic              done,
    output logic signed [7:0] ratio
);
    logic [14:0] rem_reg, rem_next;
    logic [14:0] quo_reg, quo_next;
    logic [8:0]  den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [8:0]  diff;
    logic [15:0] trial;
    logic [14:0] step_rem, step_quo;
    logic [7:0]  q8;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        diff      = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, b} - {1'b0, a});
        // one restoring step on the held operands
        trial     = {rem_reg, quo_reg[14]};
        if (trial >= {7'd0, den_reg})
        begin
            step_rem = 15'(trial - {7'd0, den_reg});
            step_quo = {quo_reg[13:0], 1'b1};
        end
        else
        begin
            step_rem = trial[14:0];
            step_quo = {quo_reg[13:0], 1'b0};
        end
        if (start)
        begin
            // magnitude numerator |a-b|*100 fits 15 bits
            quo_next  = {6'd0, diff} * 15'd100;
            rem_next  = '0;
            den_next  = {1'b0, a} + {1'b0, b};
            neg_next  = (a < b);
            cnt_next  = 4'd15;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = step_rem;
            quo_next = step_quo;
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // the final step is visible while the next division is being loaded
    assign done  = busy_reg && (cnt_reg == 4'd1);
    assign q8    = step_quo[7:0];
    assign ratio = neg_reg ? -$signed(q8) : $signed(q8);
endmodule

// ----- rtl/gdd_front.sv -----
// Collects samples, scans the store at batch end, issues commands.
module gdd_front
    import gdd_pkg::*;
#(
    parameter int BATCH_DEPTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       kind,
    input  logic [7:0] up_level,
    input  logic [7:0] down_level,
    input  logic [7:0] left_level,
    input  logic [7:0] right_level,
    input  logic       batch_last,
    input  logic [7:0] threshold,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_ready
);
    localparam int AW = $clog2(BATCH_DEPTH);
    localparam int CW = $clog2(BATCH_DEPTH + 1);

    logic [31:0]   mem [BATCH_DEPTH];
    logic [31:0]   rd_reg;
    front_state_t  st_reg, st_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] n_reg, n_next;
    logic          rdv_reg, rdv_next;
    logic [31:0]   first_reg, first_next;
    logic [31:0]   last_reg, last_next;
    cmd_kind_t     ck_reg, ck_next;
    logic          acc, wr_en, rd_en;
    logic [AW-1:0] rd_addr;
    logic          pass;

    assign acc  = push && !full;
    assign full = (st_reg != FS_COLLECT);
    assign wr_en = acc && !kind && (cnt_reg < CW'(BATCH_DEPTH));
    assign pass = (rd_reg[7:0] > threshold) && (rd_reg[15:8] > threshold)
               && (rd_reg[23:16] > threshold) && (rd_reg[31:24] > threshold);

    always_comb
    begin
        st_next    = st_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        rdv_next   = 1'b0;
        first_next = first_reg;
        last_next  = last_reg;
        ck_next    = ck_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg[AW-1:0];
        unique case (st_reg)
            FS_COLLECT:
            begin
                if (acc)
                begin
                    if (kind)
                    begin
                        ck_next  = CMD_END;
                        cnt_next = '0;
                        st_next  = FS_ISSUE;
                    end
                    else
                    begin
                        if (wr_en)
                            cnt_next = cnt_reg + CW'(1);
                        if (batch_last)
                        begin
                            n_next     = wr_en ? cnt_reg + CW'(1) : cnt_reg;
                            cnt_next   = '0;
                            idx_next   = '0;
                            if ((wr_en ? cnt_reg + CW'(1) : cnt_reg) > CW'(4))
                                st_next = FS_SCAN_FWD;
                        end
                    end
                end
            end
            FS_SCAN_FWD:
            begin
                if (rdv_reg && pass)
                begin
                    first_next = rd_reg;
                    idx_next   = n_reg - CW'(1);
                    st_next    = FS_SCAN_BWD;
                end
                else if (idx_reg < n_reg)
                begin
                    rd_en    = 1'b1;
                    rdv_next = 1'b1;
                    idx_next = idx_reg + CW'(1);
                end
                else if (!rdv_reg)
                    st_next = FS_COLLECT;
            end
            FS_SCAN_BWD:
            begin
                // a passing entry exists, so this terminates
                if (rdv_reg && pass)
                begin
                    last_next = rd_reg;
                    ck_next   = CMD_BATCH;
                    st_next   = FS_ISSUE;
                end
                else if (!rdv_reg || !pass)
                begin
                    rd_en    = 1'b1;
                    rdv_next = 1'b1;
                    idx_next = idx_reg - CW'(1);
                end
            end
            FS_ISSUE:
            begin
                if (cmd_ready)
                    st_next = FS_COLLECT;
            end
            default: st_next = FS_COLLECT;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[cnt_reg[AW-1:0]] <= {right_level, left_level, down_level, up_level};
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= FS_COLLECT;
            cnt_reg   <= '0;
            rdv_reg   <= 1'b0;
            idx_reg   <= '0;
            n_reg     <= '0;
            ck_reg    <= CMD_END;
        end
        else
        begin
            st_reg    <= st_next;
            cnt_reg   <= cnt_next;
            rdv_reg   <= rdv_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            ck_reg    <= ck_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        last_reg  <= last_next;
    end

    assign cmd_valid  = (st_reg == FS_ISSUE);
    assign cmd.kind   = ck_reg;
    assign cmd.first  = first_reg;
    assign cmd.last   = last_reg;
endmodule

// ----- rtl/gdd_back.sv -----
// Ratio, accumulation, tallies and decode; one command at a time.
module gdd_back
    import gdd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_ready,
    input  logic [7:0] swipe_sens,
    input  logic [7:0] nf_sens,
    output logic       res_valid,
    output logic [2:0] res_gesture,
    input  logic       res_ready
);
    back_state_t        st_reg, st_next;
    cmd_t               c_reg;
    cmd_t               src;
    logic [1:0]         dsel_reg, dsel_next;
    logic signed [15:0] ud_sum_reg, ud_sum_next, lr_sum_reg, lr_sum_next;
    logic signed [1:0]  ud_dir_reg, ud_dir_next, lr_dir_reg, lr_dir_next;
    logic [7:0]         near_reg, near_next, far_reg, far_next;
    prox_t              prox_reg, prox_next;
    motion_t            mot_reg, mot_next;
    logic signed [8:0]  ud_d_reg, lr_d_reg, ud_d_next, lr_d_next;
    logic               ov_reg, ov_next;
    logic [2:0]         ov_g_reg, ov_g_next;
    logic               div_start, div_done;
    logic [7:0]         da, db;
    logic signed [7:0]  div_q;
    logic signed [16:0] su, sl;
    logic [15:0]        mu, ml;
    logic               ud_wins, quiet_d, zero_d, both_nz;
    logic signed [16:0] sens;
    motion_t            dec;
    logic [8:0]         aud, alr;
    logic [7:0]         near_inc;

    gdd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (da),
        .b     (db),
        .done  (div_done),
        .ratio (div_q)
    );

    // operands of the division that starts this cycle
    always_comb
    begin
        src = (st_reg == ST_IDLE) ? cmd : c_reg;
        unique case (dsel_next)
            2'd0: begin da = src.first[7:0];   db = src.first[15:8];  end
            2'd1: begin da = src.last[7:0];    db = src.last[15:8];   end
            2'd2: begin da = src.first[23:16]; db = src.first[31:24]; end
            default: begin da = src.last[23:16]; db = src.last[31:24]; end
        endcase
    end

    always_comb
    begin
        mu = ud_sum_reg[15] ? 16'(-ud_sum_reg) : 16'(ud_sum_reg);
        ml = lr_sum_reg[15] ? 16'(-lr_sum_reg) : 16'(lr_sum_reg);
        ud_wins = {1'b0, mu} > {1'b0, ml};
        dec = mot_reg;
        if (prox_reg == PROX_NEAR)
            dec = MOTION_NEAR;
        else if (prox_reg == PROX_FAR)
            dec = MOTION_FAR;
        else if (ud_dir_reg == -2'sd1 && lr_dir_reg == 2'sd0)
            dec = MOTION_UP;
        else if (ud_dir_reg == 2'sd1 && lr_dir_reg == 2'sd0)
            dec = MOTION_DOWN;
        else if (ud_dir_reg == 2'sd0 && lr_dir_reg == 2'sd1)
            dec = MOTION_RIGHT;
        else if (ud_dir_reg == 2'sd0 && lr_dir_reg == -2'sd1)
            dec = MOTION_LEFT;
        else if (ud_dir_reg == -2'sd1 && lr_dir_reg == 2'sd1)
            dec = ud_wins ? MOTION_UP : MOTION_RIGHT;
        else if (ud_dir_reg == 2'sd1 && lr_dir_reg == -2'sd1)
            dec = ud_wins ? MOTION_DOWN : MOTION_LEFT;
        else if (ud_dir_reg == -2'sd1 && lr_dir_reg == -2'sd1)
            dec = ud_wins ? MOTION_UP : MOTION_LEFT;
        else if (ud_dir_reg == 2'sd1 && lr_dir_reg == 2'sd1)
            dec = ud_wins ? MOTION_DOWN : MOTION_RIGHT;
    end

    always_comb
    begin
        su = 17'(ud_sum_reg) + 17'(ud_d_reg);
        sl = 17'(lr_sum_reg) + 17'(lr_d_reg);
        sens = $signed({9'd0, swipe_sens});
        aud = ud_d_reg[8] ? 9'(-ud_d_reg) : 9'(ud_d_reg);
        alr = lr_d_reg[8] ? 9'(-lr_d_reg) : 9'(lr_d_reg);
        quiet_d = (aud < {1'b0, nf_sens}) && (alr < {1'b0, nf_sens});
        zero_d = (ud_d_reg == 9'sd0) && (lr_d_reg == 9'sd0);
        both_nz = (ud_d_reg != 9'sd0) && (lr_d_reg != 9'sd0);
        near_inc = (near_reg == 8'd255) ? near_reg : near_reg + 8'd1;
    end

    always_comb
    begin
        st_next     = st_reg;
        dsel_next   = dsel_reg;
        ud_sum_next = ud_sum_reg;
        lr_sum_next = lr_sum_reg;
        ud_dir_next = ud_dir_reg;
        lr_dir_next = lr_dir_reg;
        near_next   = near_reg;
        far_next    = far_reg;
        prox_next   = prox_reg;
        mot_next    = mot_reg;
        ud_d_next   = ud_d_reg;
        lr_d_next   = lr_d_reg;
        ov_next     = ov_reg;
        ov_g_next   = ov_g_reg;
        div_start   = 1'b0;
        if (ov_reg && res_ready)
            ov_next = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == CMD_END)
                    begin
                        if (!ov_reg)
                        begin
                            ov_next     = 1'b1;
                            ov_g_next   = dec;
                            ud_sum_next = '0;
                            lr_sum_next = '0;
                            ud_dir_next = '0;
                            lr_dir_next = '0;
                            near_next   = '0;
                            far_next    = '0;
                            prox_next   = PROX_NONE;
                            mot_next    = MOTION_NONE;
                        end
                    end
                    else
                    begin
                        dsel_next = 2'd0;
                        st_next   = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    unique case (dsel_reg)
                        2'd0: ud_d_next = -9'(div_q);
                        2'd1: ud_d_next = ud_d_reg + 9'(div_q);
                        2'd2: lr_d_next = -9'(div_q);
                        default: lr_d_next = lr_d_reg + 9'(div_q);
                    endcase
                    dsel_next = dsel_reg + 2'd1;
                    if (dsel_reg == 2'd3)
                        st_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                ud_sum_next = (su > 17'sd32767) ? 16'sh7fff :
                              (su < -17'sd32768) ? 16'sh8000 : 16'(su);
                lr_sum_next = (sl > 17'sd32767) ? 16'sh7fff :
                              (sl < -17'sd32768) ? 16'sh8000 : 16'(sl);
                st_next = ST_DIR;
            end
            ST_DIR:
            begin
                ud_dir_next = (17'(ud_sum_reg) >= sens) ? 2'sd1 :
                              (17'(ud_sum_reg) <= -sens) ? -2'sd1 : 2'sd0;
                lr_dir_next = (17'(lr_sum_reg) >= sens) ? 2'sd1 :
                              (17'(lr_sum_reg) <= -sens) ? -2'sd1 : 2'sd0;
                st_next = ST_TALLY;
            end
            ST_TALLY:
            begin
                st_next = ST_IDLE;
                if (ud_dir_reg == 2'sd0 && lr_dir_reg == 2'sd0)
                begin
                    if (quiet_d)
                    begin
                        if (zero_d)
                            near_next = near_inc;
                        else
                            far_next = (far_reg == 8'd255) ? far_reg : far_reg + 8'd1;
                        st_next = ST_DONE;
                    end
                end
                else if (quiet_d)
                begin
                    if (zero_d)
                        near_next = near_inc;
                    if ((zero_d ? near_inc : near_reg) >= 8'd10)
                    begin
                        ud_dir_next = '0;
                        lr_dir_next = '0;
                        ud_sum_next = '0;
                        lr_sum_next = '0;
                    end
                end
            end
            ST_DONE:
            begin
                // proximity check on updated tallies, decode uses updated prox
                st_next = ST_IDLE;
                if (near_reg >= 8'd10 && far_reg >= 8'd2)
                begin
                    if (zero_d)
                    begin
                        prox_next = PROX_NEAR;
                        mot_next  = MOTION_NEAR;
                    end
                    else if (both_nz)
                    begin
                        prox_next = PROX_FAR;
                        mot_next  = MOTION_FAR;
                    end
                    else
                        mot_next = dec;
                end
            end
            default: st_next = ST_IDLE;
        endcase
        if (st_reg == ST_DIV && st_next == ST_DIV && !div_done)
            div_start = 1'b0;
        if ((st_reg == ST_IDLE && st_next == ST_DIV)
            || (st_reg == ST_DIV && div_done && dsel_reg != 2'd3))
            div_start = 1'b1;
    end

    assign cmd_ready = (st_reg == ST_IDLE) && !(cmd.kind == CMD_END && ov_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            dsel_reg   <= '0;
            ud_sum_reg <= '0;
            lr_sum_reg <= '0;
            ud_dir_reg <= '0;
            lr_dir_reg <= '0;
            near_reg   <= '0;
            far_reg    <= '0;
            prox_reg   <= PROX_NONE;
            mot_reg    <= MOTION_NONE;
            ov_reg     <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            dsel_reg   <= dsel_next;
            ud_sum_reg <= ud_sum_next;
            lr_sum_reg <= lr_sum_next;
            ud_dir_reg <= ud_dir_next;
            lr_dir_reg <= lr_dir_next;
            near_reg   <= near_next;
            far_reg    <= far_next;
            prox_reg   <= prox_next;
            mot_reg    <= mot_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && cmd_valid)
            c_reg <= cmd;
        ud_d_reg <= ud_d_next;
        lr_d_reg <= lr_d_next;
        ov_g_reg <= ov_g_next;
    end

    assign res_valid   = ov_reg;
    assign res_gesture = ov_g_reg;
endmodule
